>>> hw/rtl/dbd_pkg.sv
`timescale 1ns / 1ps
// Package for the detector box decoder: field widths, register indexes,
// reset values and fixed-point constants. No dependencies.
package dbd_pkg;

    // Number of class scores carried by one prediction
    localparam int NUM_CLASSES       = 4;
    localparam int CLASS_W           = 2;

    // Default upper bound on the frame dimensions
    localparam int MAX_IMAGE_DIM_DEF = 4096;

    // Payload widths
    localparam int BOX_W             = 16;
    localparam int SCORE_W           = 16;
    localparam int PIX_OUT_W         = 12;

    // Configuration register widths
    localparam int PAD_W             = 10;
    localparam int SCALE_W           = 24;
    localparam int DIM_CFG_W         = 13;
    localparam int CFG_DATA_W        = 24;
    localparam int CFG_INDEX_W       = 3;

    // Corners are formed in Q.7: 2*center -/+ span - 128*pad
    localparam int PAD_SHIFT         = 7;
    localparam int CORNER_SW         = 20;
    localparam int CORNER_W          = 18;
    localparam int PROD_W            = CORNER_W + SCALE_W;
    localparam int FRAC_SHIFT        = 23;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PAD_LEFT        = 3'd0,
        REG_PAD_TOP         = 3'd1,
        REG_INVERSE_SCALE   = 3'd2,
        REG_IMAGE_WIDTH     = 3'd3,
        REG_IMAGE_HEIGHT    = 3'd4,
        REG_SCORE_THRESHOLD = 3'd5
    } cfg_reg_t;

    // Reset values of the configuration registers
    localparam logic [PAD_W-1:0]     PAD_LEFT_RST        = '0;
    localparam logic [PAD_W-1:0]     PAD_TOP_RST         = '0;
    localparam logic [SCALE_W-1:0]   INVERSE_SCALE_RST   = 24'd65536;
    localparam logic [DIM_CFG_W-1:0] IMAGE_WIDTH_RST     = 13'd640;
    localparam logic [DIM_CFG_W-1:0] IMAGE_HEIGHT_RST    = 13'd640;
    localparam logic [SCORE_W-1:0]   SCORE_THRESHOLD_RST = 16'd29491;

endpackage

>>> hw/rtl/dbd_if.sv
`timescale 1ns / 1ps
// Handshake interfaces for the detector box decoder: one for predictions,
// one for decoded boxes. Depends on dbd_pkg.

interface dbd_in_if;
    import dbd_pkg::*;

    logic               valid;
    logic               ready;
    logic [BOX_W-1:0]   center_x;
    logic [BOX_W-1:0]   center_y;
    logic [BOX_W-1:0]   box_span_x;
    logic [BOX_W-1:0]   box_span_y;
    logic [SCORE_W-1:0] score_class0;
    logic [SCORE_W-1:0] score_class1;
    logic [SCORE_W-1:0] score_class2;
    logic [SCORE_W-1:0] score_class3;

    modport source (
        output valid, center_x, center_y, box_span_x, box_span_y,
               score_class0, score_class1, score_class2, score_class3,
        input  ready
    );

    modport sink (
        input  valid, center_x, center_y, box_span_x, box_span_y,
               score_class0, score_class1, score_class2, score_class3,
        output ready
    );
endinterface

interface dbd_out_if;
    import dbd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 keep;
    logic [CLASS_W-1:0]   class_index;
    logic [SCORE_W-1:0]   confidence;
    logic [PIX_OUT_W-1:0] left;
    logic [PIX_OUT_W-1:0] top;
    logic [PIX_OUT_W-1:0] out_width;
    logic [PIX_OUT_W-1:0] out_height;

    modport source (
        output valid, keep, class_index, confidence, left, top,
               out_width, out_height,
        input  ready
    );

    modport sink (
        input  valid, keep, class_index, confidence, left, top,
               out_width, out_height,
        output ready
    );
endinterface

>>> hw/rtl/detector_box_decode.sv
`timescale 1ns / 1ps
// Detector box decoder top level: class pick, letterbox removal, scaling,
// clamping and rounding. Depends on dbd_pkg and the interfaces in dbd_if.
//
//   port     direction  carries
//   pred     sink       one prediction: centre, size, four class scores
//   result   source     keep flag, class, confidence, box in frame pixels
//   cfg_*    input      register writes: padding, scale, frame, threshold
//
// Three register stages: corners and class pick, four 18x24 multiplies,
// then clamp, rounding and output register. One request is taken every
// cycle while result does not stall.
// Reset clears the stage valid bits and loads the register defaults.
// Each stage moves on whenever the stage after it is empty or moving, so
// a stall on result only holds requests up once every stage is full.

module detector_box_decode #(
    parameter int MAX_IMAGE_DIM = dbd_pkg::MAX_IMAGE_DIM_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dbd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    dbd_in_if.sink                         pred,
    dbd_out_if.source                      result
);
    import dbd_pkg::*;

    // Width of a clamped pixel coordinate
    localparam int DIM_W = $clog2(MAX_IMAGE_DIM);

    // Configuration registers
    logic [PAD_W-1:0]     pad_left_reg;
    logic [PAD_W-1:0]     pad_top_reg;
    logic [SCALE_W-1:0]   inverse_scale_reg;
    logic [DIM_CFG_W-1:0] image_width_reg;
    logic [DIM_CFG_W-1:0] image_height_reg;
    logic [SCORE_W-1:0]   score_threshold_reg;

    // Stage 1: corners and class pick
    logic                 s1_valid_reg;
    logic [CORNER_W-1:0]  s1_corner_reg [4];
    logic [CLASS_W-1:0]   s1_class_reg;
    logic [SCORE_W-1:0]   s1_score_reg;
    logic                 s1_pass_reg;

    // Stage 2: scaled corners
    logic                 s2_valid_reg;
    logic [PROD_W-1:0]    s2_prod_reg [4];
    logic [CLASS_W-1:0]   s2_class_reg;
    logic [SCORE_W-1:0]   s2_score_reg;
    logic                 s2_pass_reg;

    // Output register
    logic                 out_valid_reg;
    logic                 keep_reg;
    logic [CLASS_W-1:0]   class_reg;
    logic [SCORE_W-1:0]   conf_reg;
    logic [PIX_OUT_W-1:0] left_reg;
    logic [PIX_OUT_W-1:0] top_reg;
    logic [PIX_OUT_W-1:0] width_reg;
    logic [PIX_OUT_W-1:0] height_reg;

    logic                 out_adv;
    logic                 s2_adv;
    logic                 s1_adv;

    logic [SCORE_W-1:0]   scores [NUM_CLASSES];
    logic [SCORE_W-1:0]   top_score;
    logic [CLASS_W-1:0]   top_class;
    logic [CORNER_W-1:0]  corner_next [4];

    logic [DIM_W-1:0]     max_pix_x;
    logic [DIM_W-1:0]     max_pix_y;
    logic [DIM_W-1:0]     pix [4];
    logic [DIM_W:0]       span_x;
    logic [DIM_W:0]       span_y;
    logic                 keep_next;

    // Corner in Q.7, negative values clamped to zero since the scale is
    // never negative
    function automatic logic [CORNER_W-1:0] make_corner(
        input logic [BOX_W-1:0] centre,
        input logic [BOX_W-1:0] span,
        input logic [PAD_W-1:0] pad,
        input logic             upper
    );
        logic signed [CORNER_SW-1:0] c2;
        logic signed [CORNER_SW-1:0] s;
        logic signed [CORNER_SW-1:0] p;
        logic signed [CORNER_SW-1:0] v;
        c2 = $signed(CORNER_SW'({centre, 1'b0}));
        s  = $signed(CORNER_SW'(span));
        p  = $signed(CORNER_SW'({pad, {PAD_SHIFT{1'b0}}}));
        v  = upper ? (c2 + s - p) : (c2 - s - p);
        return v[CORNER_SW-1] ? '0 : v[CORNER_W-1:0];
    endfunction

    // Largest pixel index for one frame dimension, saturated to the bound
    function automatic logic [DIM_W-1:0] last_pixel(
        input logic [DIM_CFG_W-1:0] dim
    );
        int d;
        d = int'(dim);
        if (d > MAX_IMAGE_DIM)
        begin
            d = MAX_IMAGE_DIM;
        end
        return (d == 0) ? '0 : DIM_W'(d - 1);
    endfunction

    // Clamp a scaled corner to [0, last] and round half up
    function automatic logic [DIM_W-1:0] clamp_round(
        input logic [PROD_W-1:0] v,
        input logic [DIM_W-1:0]  last
    );
        logic [PROD_W-1:0] lim;
        logic [DIM_W-1:0]  rnd;
        lim = PROD_W'({last, {FRAC_SHIFT{1'b0}}});
        rnd = DIM_W'(v[PROD_W-1:FRAC_SHIFT]) + DIM_W'(v[FRAC_SHIFT-1]);
        return (v > lim) ? last : rnd;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_left_reg        <= PAD_LEFT_RST;
            pad_top_reg         <= PAD_TOP_RST;
            inverse_scale_reg   <= INVERSE_SCALE_RST;
            image_width_reg     <= IMAGE_WIDTH_RST;
            image_height_reg    <= IMAGE_HEIGHT_RST;
            score_threshold_reg <= SCORE_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PAD_LEFT:        pad_left_reg        <= cfg_wdata[PAD_W-1:0];
                REG_PAD_TOP:         pad_top_reg         <= cfg_wdata[PAD_W-1:0];
                REG_INVERSE_SCALE:   inverse_scale_reg   <= cfg_wdata[SCALE_W-1:0];
                REG_IMAGE_WIDTH:     image_width_reg     <= cfg_wdata[DIM_CFG_W-1:0];
                REG_IMAGE_HEIGHT:    image_height_reg    <= cfg_wdata[DIM_CFG_W-1:0];
                REG_SCORE_THRESHOLD: score_threshold_reg <= cfg_wdata[SCORE_W-1:0];
                default:             ;
            endcase
        end
    end

    // Stage flow: a stage moves when the next one is empty or moving
    assign out_adv    = !out_valid_reg || result.ready;
    assign s2_adv     = !s2_valid_reg || out_adv;
    assign s1_adv     = !s1_valid_reg || s2_adv;
    assign pred.ready = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= pred.valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Strongest class; a later class must score strictly higher to win
    always_comb
    begin
        scores[0] = pred.score_class0;
        scores[1] = pred.score_class1;
        scores[2] = pred.score_class2;
        scores[3] = pred.score_class3;
        top_score = '0;
        top_class = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (scores[c] > top_score)
            begin
                top_score = scores[c];
                top_class = CLASS_W'(c);
            end
        end
    end

    // Corners in order left, right, top, bottom
    always_comb
    begin
        corner_next[0] = make_corner(pred.center_x, pred.box_span_x, pad_left_reg, 1'b0);
        corner_next[1] = make_corner(pred.center_x, pred.box_span_x, pad_left_reg, 1'b1);
        corner_next[2] = make_corner(pred.center_y, pred.box_span_y, pad_top_reg, 1'b0);
        corner_next[3] = make_corner(pred.center_y, pred.box_span_y, pad_top_reg, 1'b1);
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                s1_corner_reg[k] <= corner_next[k];
            end
            s1_class_reg <= top_class;
            s1_score_reg <= top_score;
            s1_pass_reg  <= (top_score != '0) && (top_score >= score_threshold_reg);
        end
    end

    // Stage 2: scale each corner by the inverse resize factor
    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                s2_prod_reg[k] <= PROD_W'(s1_corner_reg[k]) * PROD_W'(inverse_scale_reg);
            end
            s2_class_reg <= s1_class_reg;
            s2_score_reg <= s1_score_reg;
            s2_pass_reg  <= s1_pass_reg;
        end
    end

    // Clamp, round and size check
    always_comb
    begin
        max_pix_x = last_pixel(image_width_reg);
        max_pix_y = last_pixel(image_height_reg);
        pix[0]    = clamp_round(s2_prod_reg[0], max_pix_x);
        pix[1]    = clamp_round(s2_prod_reg[1], max_pix_x);
        pix[2]    = clamp_round(s2_prod_reg[2], max_pix_y);
        pix[3]    = clamp_round(s2_prod_reg[3], max_pix_y);
        span_x    = {1'b0, pix[1]} - {1'b0, pix[0]};
        span_y    = {1'b0, pix[3]} - {1'b0, pix[2]};
        keep_next = s2_pass_reg && (pix[1] > pix[0]) && (pix[3] > pix[2]);
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            keep_reg   <= keep_next;
            class_reg  <= s2_class_reg;
            conf_reg   <= s2_score_reg;
            left_reg   <= keep_next ? PIX_OUT_W'(pix[0]) : '0;
            top_reg    <= keep_next ? PIX_OUT_W'(pix[2]) : '0;
            width_reg  <= keep_next ? PIX_OUT_W'(span_x) : '0;
            height_reg <= keep_next ? PIX_OUT_W'(span_y) : '0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.keep        = keep_reg;
    assign result.class_index = class_reg;
    assign result.confidence  = conf_reg;
    assign result.left        = left_reg;
    assign result.top         = top_reg;
    assign result.out_width   = width_reg;
    assign result.out_height  = height_reg;

endmodule
